>>> src/sequential_list_engine_defines.svh
// Assertion macros shared by the sequential list engine RTL.
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define SLE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SLE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLE_ASSERT(label, clk, rst, prop, msg)
`define SLE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> src/sle_pkg.sv
// Types and constants shared by the sequential list engine modules.
`timescale 1ns / 1ps
package sle_pkg;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // per-cycle control broadcast to every cell of the chain
   typedef struct packed {
      logic ins_en;    // shift up from the insert slot, load key there
      logic del_en;    // shift down from the delete slot
      logic cmp_en;    // capture key match in every cell
      logic scan_en;   // move match flags one cell toward the head
   } cell_ctl_type;

endpackage

>>> src/sle_cell.sv
// One list cell: holds one entry and its match flag, trades both with its neighbors.
`timescale 1ns / 1ps
module sle_cell
   import sle_pkg::*;
#(
   parameter int CW    = 6,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic [CW-1:0]             slot,
   input  logic signed [VALUE_W-1:0] key,
   input  logic signed [VALUE_W-1:0] left_data,
   input  logic signed [VALUE_W-1:0] right_data,
   input  logic                      right_match,
   output logic signed [VALUE_W-1:0] data,
   output logic                      match
);

   localparam logic [CW-1:0] MY_SLOT = CW'(INDEX);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;
   logic                      match_ff;
   logic                      match_in;

   // pick the next entry: hold, take a neighbor, or load the key
   always_comb begin
      data_in = data_ff;
      if (ctl.ins_en) begin
         if (MY_SLOT > slot) begin
            data_in = left_data;
         end else if (MY_SLOT == slot) begin
            data_in = key;
         end
      end else if (ctl.del_en) begin
         if (MY_SLOT >= slot) begin
            data_in = right_data;
         end
      end
   end

   // capture the compare result, then advance it toward the head
   always_comb begin
      match_in = match_ff;
      if (ctl.cmp_en) begin
         match_in = (data_ff == key);
      end else if (ctl.scan_en) begin
         match_in = right_match;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

>>> src/sequential_list_engine.sv
// Top level of the sequential list engine: request decode, length count, cell chain, result.
// Insert, delete and unused modes: result in the cycle after the item is taken, next item
//   may follow at once (one item per cycle).
// Locate on a non-empty list: match flags are captured in all cells, then walk one cell per cycle
//   toward the head; busy is high until the result is registered.
// Synchronous active-high reset empties the list; entries themselves are not cleared.
`timescale 1ns / 1ps
module sequential_list_engine
   import sle_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_item_value,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_removed_value,
   output logic [POS_W-1:0]           rsp_found_position
);

`include "sequential_list_engine_defines.svh"

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = $clog2(CAPACITY);
   localparam int PW = ((LW > POS_W) ? LW : POS_W) + 1;
   localparam int FW = ((LW + 1) > POS_W) ? (LW + 1) : POS_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                      state_ff;
   logic                      state_in;
   logic [LW-1:0]             len_ff;
   logic [LW-1:0]             len_in;
   logic [LW-1:0]             cnt_ff;
   logic [LW-1:0]             cnt_in;
   logic [LW-1:0]             cnt_next;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [STATUS_W-1:0]       rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_removed_ff;
   logic signed [VALUE_W-1:0] rsp_removed_in;
   logic [POS_W-1:0]          rsp_found_ff;
   logic [POS_W-1:0]          rsp_found_in;

   logic                      accept;
   logic [PW-1:0]             pos_ext;
   logic [PW-1:0]             len_ext;
   logic                      ins_range_err;
   logic                      list_full;
   logic                      del_ok;
   logic [PW-1:0]             slot_wide;
   logic [CW-1:0]             slot;
   logic [FW-1:0]             found_wide;
   cell_ctl_type              ctl;

   logic signed [VALUE_W-1:0] cell_data  [CAPACITY];
   logic                      cell_match [CAPACITY];

   // decode the request against the current length
   assign accept        = start && !busy;
   assign pos_ext       = PW'(req_position);
   assign len_ext       = PW'(len_ff);
   assign ins_range_err = (pos_ext == '0) || (pos_ext > (len_ext + 1'b1));
   assign list_full     = (len_ff == LW'(CAPACITY));
   assign del_ok        = (pos_ext != '0) && (pos_ext <= len_ext);
   assign slot_wide     = pos_ext - 1'b1;
   assign slot          = slot_wide[CW-1:0];
   assign cnt_next      = cnt_ff + 1'b1;
   assign found_wide    = FW'(cnt_ff) + 1'b1;

   // sequence requests and the locate walk
   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      ctl            = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in  = STATUS_OK;
               rsp_removed_in = '0;
               rsp_found_in   = '0;
               case (req_mode)
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (ins_range_err) begin
                        rsp_status_in = STATUS_RANGE;
                     end else if (list_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctl.ins_en = 1'b1;
                        len_in     = len_ff + 1'b1;
                     end
                  end
                  MODE_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (del_ok) begin
                        ctl.del_en     = 1'b1;
                        len_in         = len_ff - 1'b1;
                        rsp_removed_in = cell_data[slot];
                     end else begin
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  MODE_LOCATE: begin
                     if (len_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        ctl.cmp_en = 1'b1;
                        cnt_in     = '0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cell_match[0]) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_found_in  = found_wide[POS_W-1:0];
               state_in      = S_IDLE;
            end else if (cnt_next == len_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_found_in  = '0;
               state_in      = S_IDLE;
            end else begin
               ctl.scan_en = 1'b1;
               cnt_in      = cnt_next;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
   end

   // chain of cells, head at index zero
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_data;
      logic signed [VALUE_W-1:0] right_data;
      logic                      right_match;

      if (g == 0) begin : g_head
         assign left_data = req_item_value;
      end else begin : g_body
         assign left_data = cell_data[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_data  = cell_data[g];
         assign right_match = 1'b0;
      end else begin : g_inner
         assign right_data  = cell_data[g+1];
         assign right_match = cell_match[g+1];
      end

      sle_cell #(
         .CW    (CW),
         .INDEX (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .slot        (slot),
         .key         (req_item_value),
         .left_data   (left_data),
         .right_data  (right_data),
         .right_match (right_match),
         .data        (cell_data[g]),
         .match       (cell_match[g])
      );
   end

   assign busy               = (state_ff == S_SCAN);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_found_ff;

   // checks
   `SLE_ASSERT_ALWAYS(a_len_bound, clock, reset || (len_ff <= LW'(CAPACITY)), "list length above capacity")
   `SLE_ASSERT(a_scan_nonempty, clock, reset, busy |-> (len_ff != '0), "locate walk on empty list")
   `SLE_ASSERT(a_ins_grows, clock, reset, ctl.ins_en |=> (len_ff == $past(len_ff) + 1'b1), "insert did not grow list")
   `SLE_ASSERT(a_del_result, clock, reset, (accept && (req_mode == MODE_DELETE)) |=> rsp_valid, "delete gave no result")
   `SLE_ASSERT(a_found_clean, clock, reset, (rsp_valid && (rsp_found_position != '0)) |-> ((rsp_status == STATUS_OK) && (rsp_removed_value == '0)), "locate result mixed with other fields")

endmodule

>>> tb/sv/sle_list_checker.sv
// Checker for the sequential list engine: list predictor and result comparison.
`timescale 1ns / 1ps
module sle_list_checker
   import sle_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic                      rsp_valid,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic signed [VALUE_W-1:0] rsp_removed_value,
   input  logic [POS_W-1:0]          rsp_found_position,
   output int                        fail_count,
   output int                        pending,
   output int                        predicted_length
);

   typedef struct packed {
      logic [STATUS_W-1:0]        status;
      logic signed [VALUE_W-1:0]  removed;
      logic [POS_W-1:0]           found;
   } list_result_type;

   // shadow copy of the list
   logic signed [VALUE_W-1:0] list_mem [CAPACITY];
   int list_len = 0;
   int errors = 0;
   list_result_type result_q [$];

   // apply one request to the shadow list and return the result it gives
   function automatic list_result_type apply_request(input logic [MODE_W-1:0] mode,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VALUE_W-1:0] val);
      list_result_type res;
      int k;
      int p;
      res = '0;
      res.status = STATUS_OK;
      p = int'(pos);
      case (mode)
         MODE_INSERT: begin
            if (p < 1 || p > list_len + 1) begin
               res.status = STATUS_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               for (k = list_len; k >= p; k--)
                  list_mem[k] = list_mem[k-1];
               list_mem[p-1] = val;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (p < 1 || p > list_len) begin
               res.status = STATUS_RANGE;
            end else begin
               res.removed = list_mem[p-1];
               for (k = p; k < list_len; k++)
                  list_mem[k-1] = list_mem[k];
               list_len--;
            end
         end
         MODE_LOCATE: begin
            // first match wins
            for (k = 0; k < list_len; k++)
               if (res.found == '0 && list_mem[k] == val)
                  res.found = POS_W'(k + 1);
         end
         default: ;
      endcase
      return res;
   endfunction

   // compare each result with the oldest prediction, then predict new items
   always @(posedge clock) begin : watch
      list_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (result_q.size() == 0) begin
               $display("%0t: result with nothing expected: status %0d removed %0d found %0d",
                        $time, rsp_status, rsp_removed_value, rsp_found_position);
               errors++;
            end else begin
               want = result_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_removed_value !== want.removed) begin
                  $display("%0t: removed_value expected %0d actual %0d",
                           $time, want.removed, rsp_removed_value);
                  errors++;
               end
               if (rsp_found_position !== want.found) begin
                  $display("%0t: found_position expected %0d actual %0d",
                           $time, want.found, rsp_found_position);
                  errors++;
               end
            end
         end
         if (start && !busy)
            result_q.push_back(apply_request(req_mode, req_position, req_item_value));
      end
      fail_count <= errors;
      pending <= result_q.size();
      predicted_length <= list_len;
   end

endmodule

>>> tb/sv/tb_sequential_list_engine.sv
// Testbench top for the sequential list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_sequential_list_engine;
   import sle_pkg::*;

   localparam int LIST_CAP = 64;
   localparam int STALL_LIMIT = 4000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_W-1:0] req_mode = '0;
   logic [POS_W-1:0] req_position = '0;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic [POS_W-1:0] rsp_found_position;

   int fail_count;
   int pending;
   int predicted_length;
   int quiet_cycles = 0;

   // recently inserted values, used to aim locate at real entries
   logic signed [VALUE_W-1:0] value_log [LIST_CAP];
   int log_wr = 0;
   int log_fill = 0;

   sequential_list_engine #(.CAPACITY(LIST_CAP)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position)
   );

   sle_list_checker #(.CAPACITY(LIST_CAP)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_position       (req_position),
      .req_item_value     (req_item_value),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_removed_value  (rsp_removed_value),
      .rsp_found_position (rsp_found_position),
      .fail_count         (fail_count),
      .pending            (pending),
      .predicted_length   (predicted_length)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // present one item and hold it until the engine takes it
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic signed [VALUE_W-1:0] val);
      start <= 1'b1;
      req_mode <= mode;
      req_position <= pos;
      req_item_value <= val;
      if (mode == MODE_INSERT) begin
         value_log[log_wr] = val;
         log_wr = (log_wr + 1) % LIST_CAP;
         if (log_fill < LIST_CAP)
            log_fill++;
      end
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // drop start and wait until every expected result is in
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
         1, 2: return $signed(VALUE_W'($urandom_range(0, 15))) - 8;
         default: return $urandom;
      endcase
   endfunction

   // random items; weights in percent, 6 percent noise, the rest locate
   task automatic run_phase(input int count, input int insert_w, input int delete_w,
                            input bit allow_idle);
      int n;
      int r;
      int len;
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0] pos;
      logic signed [VALUE_W-1:0] val;
      for (n = 0; n < count; n++) begin
         len = predicted_length;
         r = $urandom_range(0, 99);
         val = pick_value();
         if (r < 6) begin
            // noise: unused mode or any mode with any position
            mode = $urandom_range(0, 1) ? MODE_UNUSED : MODE_W'($urandom_range(0, 3));
            pos = POS_W'($urandom_range(0, 127));
            val = $urandom;
         end else if (r < 6 + insert_w) begin
            mode = MODE_INSERT;
            if ($urandom_range(0, 9) == 0)
               pos = POS_W'((len + 2 <= 127 && $urandom_range(0, 1)) ?
                            $urandom_range(len + 2, 127) : 0);
            else
               pos = POS_W'($urandom_range(1, len + 1));
         end else if (r < 6 + insert_w + delete_w) begin
            mode = MODE_DELETE;
            if ($urandom_range(0, 9) == 0)
               pos = POS_W'($urandom_range(0, 1) ? $urandom_range(len + 1, 127) : 0);
            else
               pos = POS_W'((len == 0) ? 1 : $urandom_range(1, len));
         end else begin
            mode = MODE_LOCATE;
            pos = POS_W'($urandom_range(0, 127));
            if (log_fill > 0 && $urandom_range(0, 9) < 7)
               val = value_log[$urandom_range(0, log_fill - 1)];
         end
         send_item(mode, pos, val);
         if (allow_idle && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 16));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, range checks, extremes, duplicates, unused mode
      send_item(MODE_LOCATE, 7'd0, 32'sd5);
      send_item(MODE_DELETE, 7'd1, 32'sd0);
      send_item(MODE_INSERT, 7'd0, 32'sd1);
      send_item(MODE_INSERT, 7'd2, 32'sd1);
      send_item(MODE_INSERT, 7'd1, VALUE_MIN);
      send_item(MODE_INSERT, 7'd2, VALUE_MAX);
      send_item(MODE_INSERT, 7'd1, -32'sd1);
      send_item(MODE_INSERT, 7'd127, 32'sd3);
      send_item(MODE_INSERT, 7'd4, 32'sd0);
      send_item(MODE_INSERT, 7'd2, 32'sd0);
      send_item(MODE_LOCATE, 7'd127, 32'sd0);
      send_item(MODE_LOCATE, 7'd0, VALUE_MAX);
      send_item(MODE_LOCATE, 7'd0, 32'sd12345);
      send_item(MODE_DELETE, 7'd0, 32'sd0);
      send_item(MODE_DELETE, 7'd6, 32'sd0);
      send_item(MODE_DELETE, 7'd127, -32'sd1);
      send_item(MODE_DELETE, 7'd3, 32'sd0);
      send_item(MODE_DELETE, 7'd4, 32'sd0);
      send_item(MODE_UNUSED, 7'd127, -32'sd1);
      send_item(MODE_DELETE, 7'd1, 32'sd0);
      send_item(MODE_LOCATE, 7'd1, -32'sd1);
      send_item(MODE_DELETE, 7'd1, 32'sd0);
      send_item(MODE_DELETE, 7'd1, 32'sd0);
      settle();

      // random: fill up, churn, grow, drain, refill, churn; third and last phases without gaps
      run_phase(400, 70, 10, 1'b1);
      run_phase(400, 35, 30, 1'b1);
      settle();
      run_phase(300, 40, 15, 1'b0);
      run_phase(400, 15, 65, 1'b1);
      run_phase(300, 65, 15, 1'b1);
      run_phase(200, 35, 35, 1'b0);

      settle();
      repeat (LIST_CAP + 8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/sle_pkg.sv
src/sle_cell.sv
src/sequential_list_engine.sv
tb/sv/sle_list_checker.sv
tb/sv/tb_sequential_list_engine.sv
